/* rtl/core/cts_pkg.sv */
// ----------------------------------------------------------------------------
// cts_pkg - capture timestamp FIFO shared types and constants
// Command and status codes, register map and fixed field widths.
// ----------------------------------------------------------------------------
package cts_pkg;

   localparam int SLOT_CH    = 16;
   localparam int CH_W       = 4;
   localparam int MAX_TIMERS = 4;
   localparam int GRP_W      = 2;
   localparam int VALUE_W    = 16;
   localparam int COARSE_W   = 48;
   localparam int STAMP_W    = 64;
   localparam int FILL_W     = 6;
   localparam int THR_W      = 8;
   localparam int MASK_W     = 16;
   localparam int APB_AW     = 3;
   localparam int APB_DW     = 32;

   localparam logic [THR_W-1:0]  THR_RESET  = 8'd15;
   localparam logic [MASK_W-1:0] MASK_RESET = 16'hBFFF;

   typedef enum logic [1:0] {
      CMD_CAPTURE = 2'd0,
      CMD_WRAP    = 2'd1,
      CMD_POP     = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_STORED    = 3'd0,
      ST_DROPPED   = 3'd1,
      ST_POPPED    = 3'd2,
      ST_POP_EMPTY = 3'd3,
      ST_WRAP      = 3'd4
   } status_type;

   typedef enum logic {
      REG_THRESHOLD = 1'b0,
      REG_ENABLE    = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [THR_W-1:0]  ready_threshold;
      logic [MASK_W-1:0] channel_enable_mask;
   } cfg_type;

endpackage

/* rtl/core/cts_req_if.sv */
// ----------------------------------------------------------------------------
// cts_req_if - capture timestamp request channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface cts_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    cmd;
   logic [cts_pkg::CH_W-1:0]      channel;
   logic [cts_pkg::VALUE_W-1:0]   captured_value;
   logic [cts_pkg::VALUE_W-1:0]   counter_now;
   logic                          wrap_pending;
   logic                          pin_level;

   modport source (output valid, cmd, channel, captured_value, counter_now,
                   wrap_pending, pin_level, input ready);
   modport sink   (input valid, cmd, channel, captured_value, counter_now,
                   wrap_pending, pin_level, output ready);
endinterface

/* rtl/core/cts_rsp_if.sv */
// ----------------------------------------------------------------------------
// cts_rsp_if - capture timestamp response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface cts_rsp_if;
   logic                          valid;
   logic                          ready;
   cts_pkg::status_type           status;
   logic [cts_pkg::STAMP_W-1:0]   timestamp_word;
   logic [cts_pkg::FILL_W-1:0]    channel_fill;
   logic                          group_ready;

   modport source (output valid, status, timestamp_word, channel_fill,
                   group_ready, input ready);
   modport sink   (input valid, status, timestamp_word, channel_fill,
                   group_ready, output ready);
endinterface

/* rtl/core/cts_csr.sv */
// ----------------------------------------------------------------------------
// cts_csr - configuration registers
// APB-style register file for the ready threshold and channel enable mask.
// ----------------------------------------------------------------------------
module cts_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cts_pkg::APB_AW-1:0]    paddr,
   input  logic [cts_pkg::APB_DW-1:0]    pwdata,
   output logic [cts_pkg::APB_DW-1:0]    prdata,
   output logic                          pready,
   output cts_pkg::cfg_type              cfg
);

   cts_pkg::cfg_type      cfg_ff;
   cts_pkg::cfg_type      cfg_in;
   cts_pkg::reg_index_type reg_sel;
   logic                  wr_en;

   assign pready  = 1'b1;
   assign reg_sel = cts_pkg::reg_index_type'(paddr[2]);
   assign wr_en   = psel && penable && pwrite && pready;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            cts_pkg::REG_THRESHOLD:
               cfg_in.ready_threshold = pwdata[cts_pkg::THR_W-1:0];
            cts_pkg::REG_ENABLE:
               cfg_in.channel_enable_mask = pwdata[cts_pkg::MASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         cts_pkg::REG_THRESHOLD:
            prdata = cts_pkg::APB_DW'(cfg_ff.ready_threshold);
         cts_pkg::REG_ENABLE:
            prdata = cts_pkg::APB_DW'(cfg_ff.channel_enable_mask);
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ready_threshold     <= cts_pkg::THR_RESET;
         cfg_ff.channel_enable_mask <= cts_pkg::MASK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/cts_store.sv */
// ----------------------------------------------------------------------------
// cts_store - timestamp FIFO storage
// One write port and one registered read port shared by all channel FIFOs.
// ----------------------------------------------------------------------------
module cts_store #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [cts_pkg::STAMP_W-1:0]   wr_data,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [cts_pkg::STAMP_W-1:0]   rd_data
);

   logic [cts_pkg::STAMP_W-1:0] mem [DEPTH];
   logic [cts_pkg::STAMP_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

/* rtl/core/capture_timestamp_fifo_core.sv */
// ----------------------------------------------------------------------------
// capture_timestamp_fifo_core - input capture timestamp extension and FIFOs
//
// req_chan takes one command word per handshake: capture, timer wrap or pop.
// A capture is extended with the 48-bit wrap count into a 64-bit timestamp
// (shifted left one, pin level in bit 0) and pushed to its channel FIFO.
// A wrap advances the wrap count; a pop reads the channel FIFO head.
// Every accepted word gives exactly one word on rsp_chan: status, timestamp,
// channel fill and timer group readiness.
// The result register holds the word from the cycle after acceptance.
// Throughput is one word per cycle unless rsp_chan stalls; the FIFO storage
// takes one write or one read per word and the result register is one deep.
// When rsp_chan stalls, the result is held and req_chan.ready drops until it
// is taken. Reset empties all FIFOs, clears the wrap count and loads the
// register defaults (threshold 15, channel 14 disabled); req_chan.ready is
// low while reset is high. FIFO contents are not cleared, so no clearing
// pass is needed.
// The APB-style port sits at byte address 0 (threshold) and 4 (enable mask).
// ----------------------------------------------------------------------------
module capture_timestamp_fifo_core #(
   parameter int FIFO_DEPTH         = 32,
   parameter int CHANNELS_PER_TIMER = 4,
   parameter int TIMER_COUNT        = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   cts_req_if.sink                       req_chan,
   cts_rsp_if.source                     rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cts_pkg::APB_AW-1:0]    paddr,
   input  logic [cts_pkg::APB_DW-1:0]    pwdata,
   output logic [cts_pkg::APB_DW-1:0]    prdata,
   output logic                          pready
);

   localparam int NUM_CH = TIMER_COUNT * CHANNELS_PER_TIMER;
   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int SUM_W  = $clog2(CHANNELS_PER_TIMER * FIFO_DEPTH + 1);
   localparam int CMP_W  = (SUM_W > cts_pkg::THR_W) ? SUM_W : cts_pkg::THR_W;
   localparam int MEM_D  = NUM_CH * FIFO_DEPTH;
   localparam int MEM_AW = $clog2(MEM_D);

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   cts_pkg::cfg_type                 cfg;

   logic [cts_pkg::COARSE_W-1:0]     coarse_ff, coarse_in;
   logic [PTR_W-1:0]                 head_ff [cts_pkg::SLOT_CH];
   logic [PTR_W-1:0]                 head_in [cts_pkg::SLOT_CH];
   logic [PTR_W-1:0]                 tail_ff [cts_pkg::SLOT_CH];
   logic [PTR_W-1:0]                 tail_in [cts_pkg::SLOT_CH];
   logic [CNT_W-1:0]                 count_ff [cts_pkg::SLOT_CH];
   logic [CNT_W-1:0]                 count_in [cts_pkg::SLOT_CH];
   logic [SUM_W-1:0]                 gsum_ff [cts_pkg::MAX_TIMERS];
   logic [SUM_W-1:0]                 gsum_in [cts_pkg::MAX_TIMERS];

   logic                             rsp_valid_ff, rsp_valid_in;
   cts_pkg::status_type              status_ff, status_in;
   logic [cts_pkg::STAMP_W-1:0]      word_ff, word_in;
   logic                             pop_sel_ff;
   logic [cts_pkg::FILL_W-1:0]       fill_ff, fill_in;
   logic                             grdy_ff, grdy_in;

   logic                             accept;
   cts_pkg::cmd_type                 cmd;
   logic [cts_pkg::CH_W-1:0]         ch;
   logic                             ch_ok;
   logic [cts_pkg::GRP_W-1:0]        grp;
   logic [CNT_W-1:0]                 cur_cnt, cnt_nx;
   logic [SUM_W-1:0]                 sum_nx;
   logic                             do_store, do_pop;
   logic                             bump;
   logic [cts_pkg::COARSE_W-1:0]     ext_hi;
   logic [cts_pkg::STAMP_W-1:0]      stamp;
   logic [MEM_AW-1:0]                wr_addr, rd_addr;
   logic [cts_pkg::STAMP_W-1:0]      rd_data;

   cts_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign cmd            = cts_pkg::cmd_type'(req_chan.cmd);
   assign ch             = req_chan.channel;
   assign ch_ok          = {1'b0, ch} < (cts_pkg::CH_W + 1)'(NUM_CH);
   assign cur_cnt        = count_ff[ch];

   // timer group of the addressed channel
   always_comb begin
      grp = '0;
      for (int g = 0; g < TIMER_COUNT; g++) begin
         if ({1'b0, ch} >= (cts_pkg::CH_W + 1)'(g * CHANNELS_PER_TIMER) &&
             {1'b0, ch} < (cts_pkg::CH_W + 1)'((g + 1) * CHANNELS_PER_TIMER)) begin
            grp = cts_pkg::GRP_W'(g);
         end
      end
   end

   always_comb begin
      do_store  = 1'b0;
      do_pop    = 1'b0;
      status_in = cts_pkg::ST_DROPPED;
      case (cmd)
         cts_pkg::CMD_CAPTURE: begin
            if (ch_ok && cfg.channel_enable_mask[ch] &&
                cur_cnt < CNT_W'(FIFO_DEPTH)) begin
               do_store  = 1'b1;
               status_in = cts_pkg::ST_STORED;
            end
         end
         cts_pkg::CMD_WRAP: begin
            status_in = cts_pkg::ST_WRAP;
         end
         cts_pkg::CMD_POP: begin
            if (ch_ok && cur_cnt != '0) begin
               do_pop    = 1'b1;
               status_in = cts_pkg::ST_POPPED;
            end else begin
               status_in = cts_pkg::ST_POP_EMPTY;
            end
         end
         default: ;
      endcase
   end

   // wrap pending and capture below service value: capture is in next period
   assign bump    = req_chan.wrap_pending && (req_chan.captured_value < req_chan.counter_now);
   assign ext_hi  = coarse_ff + cts_pkg::COARSE_W'(bump);
   assign stamp   = {ext_hi[cts_pkg::COARSE_W-2:0], req_chan.captured_value,
                     req_chan.pin_level};
   assign word_in = do_store ? stamp : '0;

   assign cnt_nx  = do_store ? cur_cnt + 1'b1 : (do_pop ? cur_cnt - 1'b1 : cur_cnt);
   assign sum_nx  = do_store ? gsum_ff[grp] + 1'b1 :
                    (do_pop ? gsum_ff[grp] - 1'b1 : gsum_ff[grp]);
   assign fill_in = ch_ok ? cts_pkg::FILL_W'(cnt_nx) : '0;
   assign grdy_in = ch_ok && (CMP_W'(sum_nx) > CMP_W'(cfg.ready_threshold));

   always_comb begin
      coarse_in = coarse_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      gsum_in   = gsum_ff;
      if (accept) begin
         if (cmd == cts_pkg::CMD_WRAP) begin
            coarse_in = coarse_ff + 1'b1;
         end
         if (do_store) begin
            tail_in[ch] = next_slot(tail_ff[ch]);
         end
         if (do_pop) begin
            head_in[ch] = next_slot(head_ff[ch]);
         end
         count_in[ch] = cnt_nx;
         gsum_in[grp] = sum_nx;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   assign wr_addr = MEM_AW'(32'(ch) * FIFO_DEPTH + 32'(tail_ff[ch]));
   assign rd_addr = MEM_AW'(32'(ch) * FIFO_DEPTH + 32'(head_ff[ch]));

   cts_store #(
      .DEPTH  (MEM_D),
      .ADDR_W (MEM_AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept && do_store),
      .wr_addr (wr_addr),
      .wr_data (stamp),
      .rd_en   (accept && do_pop),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         coarse_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < cts_pkg::SLOT_CH; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         for (int g = 0; g < cts_pkg::MAX_TIMERS; g++) begin
            gsum_ff[g] <= '0;
         end
      end else begin
         coarse_ff    <= coarse_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         gsum_ff      <= gsum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         word_ff    <= word_in;
         pop_sel_ff <= do_pop;
         fill_ff    <= fill_in;
         grdy_ff    <= grdy_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.timestamp_word = pop_sel_ff ? rd_data : word_ff;
   assign rsp_chan.channel_fill   = fill_ff;
   assign rsp_chan.group_ready    = grdy_ff;

   a_wrap_reported: assert property (@(posedge clock) disable iff (reset)
      accept && cmd == cts_pkg::CMD_WRAP |=>
         rsp_chan.valid && rsp_chan.status == cts_pkg::ST_WRAP)
      else $error("wrap word not reported as wrap");

   a_bad_channel: assert property (@(posedge clock) disable iff (reset)
      accept && !ch_ok |=> rsp_chan.channel_fill == '0 && !rsp_chan.group_ready)
      else $error("out of range channel reports fill or ready");

   a_zero_word: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != cts_pkg::ST_STORED &&
      rsp_chan.status != cts_pkg::ST_POPPED |-> rsp_chan.timestamp_word == '0)
      else $error("nonzero timestamp on non-data status");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      accept |-> cur_cnt <= CNT_W'(FIFO_DEPTH) && sum_nx >= SUM_W'(cnt_nx))
      else $error("FIFO fill out of range or group sum below channel fill");

   a_pop_reads: assert property (@(posedge clock) disable iff (reset)
      accept && do_pop |=> pop_sel_ff && rsp_chan.status == cts_pkg::ST_POPPED)
      else $error("pop did not select storage read data");

endmodule

/* verif/capture_timestamp_checker.sv */
// ----------------------------------------------------------------------------
// capture_timestamp_checker - result predictor and scoreboard
// Watches the request, result and register ports of the capture timestamp
// core, keeps its own wrap count, per-channel FIFOs and register copies, and
// compares every result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module capture_timestamp_checker (
   input  logic                       clock,
   input  logic                       reset,
   cts_req_if                         req_mon,
   cts_rsp_if                         rsp_mon,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic                       pready,
   input  logic [cts_pkg::APB_AW-1:0] paddr,
   input  logic [cts_pkg::APB_DW-1:0] pwdata,
   output int                         pending_words,
   output int                         fail_count
);

   localparam int FIFO_DEPTH = 32;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);

   typedef struct packed {
      cts_pkg::status_type         status;
      logic [cts_pkg::STAMP_W-1:0] stamp;
      logic [cts_pkg::FILL_W-1:0]  fill;
      logic                        ready;
   } stamp_result_type;

   logic [cts_pkg::COARSE_W-1:0] wrap_count;
   logic [cts_pkg::STAMP_W-1:0]  stamp_mem [cts_pkg::SLOT_CH][FIFO_DEPTH];
   logic [PTR_W-1:0]             rd_ptr [cts_pkg::SLOT_CH];
   logic [PTR_W-1:0]             wr_ptr [cts_pkg::SLOT_CH];
   logic [cts_pkg::FILL_W-1:0]   fill_cnt [cts_pkg::SLOT_CH];
   logic [cts_pkg::THR_W-1:0]    thr_reg;
   logic [cts_pkg::MASK_W-1:0]   enable_reg;
   stamp_result_type             expected_q [$];

   task automatic report_mismatch(string what, logic [cts_pkg::STAMP_W-1:0] got,
                                  logic [cts_pkg::STAMP_W-1:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   // Applies one command word to the model state and returns its result.
   function automatic stamp_result_type predict_stamp(cts_pkg::cmd_type c,
                                                      logic [cts_pkg::CH_W-1:0] ch,
                                                      logic [cts_pkg::VALUE_W-1:0] cap,
                                                      logic [cts_pkg::VALUE_W-1:0] now,
                                                      logic pend, logic pin);
      stamp_result_type            r;
      logic [cts_pkg::STAMP_W-1:0] ext;
      logic [cts_pkg::CH_W-1:0]    base;
      int                          group_sum;
      r.status = cts_pkg::ST_DROPPED;
      r.stamp  = '0;
      case (c)
         cts_pkg::CMD_CAPTURE: begin
            if (enable_reg[ch] && fill_cnt[ch] < FIFO_DEPTH) begin
               ext = {wrap_count, 16'h0000} + cap;
               // capture taken just after the wrap belongs to the next period
               if (pend && cap < now) ext = ext + 64'h1_0000;
               r.stamp = {ext[cts_pkg::STAMP_W-2:0], pin};
               stamp_mem[ch][wr_ptr[ch]] = r.stamp;
               wr_ptr[ch] = wr_ptr[ch] + 1'b1;
               fill_cnt[ch] = fill_cnt[ch] + 1'b1;
               r.status = cts_pkg::ST_STORED;
            end
         end
         cts_pkg::CMD_WRAP: begin
            wrap_count = wrap_count + 1'b1;
            r.status = cts_pkg::ST_WRAP;
         end
         cts_pkg::CMD_POP: begin
            if (fill_cnt[ch] != 0) begin
               r.stamp = stamp_mem[ch][rd_ptr[ch]];
               rd_ptr[ch] = rd_ptr[ch] + 1'b1;
               fill_cnt[ch] = fill_cnt[ch] - 1'b1;
               r.status = cts_pkg::ST_POPPED;
            end else begin
               r.status = cts_pkg::ST_POP_EMPTY;
            end
         end
         default: ;
      endcase
      r.fill = fill_cnt[ch];
      base = {ch[cts_pkg::CH_W-1:2], 2'b00};
      group_sum = 0;
      for (int i = 0; i < 4; i++) group_sum += fill_cnt[base + i];
      r.ready = (group_sum > int'(thr_reg));
      return r;
   endfunction

   always @(posedge clock) begin
      stamp_result_type want;
      if (reset) begin
         wrap_count = '0;
         thr_reg    = cts_pkg::THR_RESET;
         enable_reg = cts_pkg::MASK_RESET;
         for (int i = 0; i < cts_pkg::SLOT_CH; i++) begin
            rd_ptr[i]   = '0;
            wr_ptr[i]   = '0;
            fill_cnt[i] = '0;
         end
         expected_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result word", rsp_mon.timestamp_word, '0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", cts_pkg::STAMP_W'(rsp_mon.status),
                                  cts_pkg::STAMP_W'(want.status));
               if (rsp_mon.timestamp_word !== want.stamp)
                  report_mismatch("timestamp_word", rsp_mon.timestamp_word, want.stamp);
               if (rsp_mon.channel_fill !== want.fill)
                  report_mismatch("channel_fill", cts_pkg::STAMP_W'(rsp_mon.channel_fill),
                                  cts_pkg::STAMP_W'(want.fill));
               if (rsp_mon.group_ready !== want.ready)
                  report_mismatch("group_ready", cts_pkg::STAMP_W'(rsp_mon.group_ready),
                                  cts_pkg::STAMP_W'(want.ready));
            end
         end
         if (psel && penable && pwrite && pready) begin
            if (cts_pkg::reg_index_type'(paddr[2]) == cts_pkg::REG_THRESHOLD)
               thr_reg = pwdata[cts_pkg::THR_W-1:0];
            else
               enable_reg = pwdata[cts_pkg::MASK_W-1:0];
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_q.push_back(predict_stamp(cts_pkg::cmd_type'(req_mon.cmd),
                                               req_mon.channel,
                                               req_mon.captured_value, req_mon.counter_now,
                                               req_mon.wrap_pending, req_mon.pin_level));
         end
      end
      pending_words <= expected_q.size();
   end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - capture timestamp FIFO core testbench
// Drives directed and random capture, wrap, pop and no-op words under several
// register settings and idle/stall mixes; the checker predicts each result.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int SEG_WORDS   = 216;
   localparam int SEGMENTS    = 8;
   localparam int STALL_LIMIT = 2000;

   localparam logic [cts_pkg::THR_W-1:0]  THR_SET  [SEGMENTS] = '{8'd0, 8'd255, 8'd7,
                                                                 8'd0, 8'd40, 8'd1,
                                                                 8'd0, 8'd15};
   localparam logic [cts_pkg::MASK_W-1:0] MASK_SET [SEGMENTS] = '{16'hFFFF, 16'h0000,
                                                                 16'h5A5A, 16'h0000,
                                                                 16'hFFFF, 16'hA5A5,
                                                                 16'h0000, 16'hBFFF};

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [cts_pkg::APB_AW-1:0] paddr;
   logic [cts_pkg::APB_DW-1:0] pwdata;
   logic [cts_pkg::APB_DW-1:0] prdata;
   logic                       pready;
   int                         idle_pct;
   int                         stall_pct;
   int                         words_sent;
   int                         quiet_cycles;
   int                         pending_words;
   int                         fail_count;

   cts_req_if req_bus ();
   cts_rsp_if rsp_bus ();

   capture_timestamp_fifo_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   capture_timestamp_checker u_stamp_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .pending_words (pending_words),
      .fail_count    (fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_word(cts_pkg::cmd_type c, logic [cts_pkg::CH_W-1:0] ch,
                            logic [cts_pkg::VALUE_W-1:0] cap,
                            logic [cts_pkg::VALUE_W-1:0] now, logic pend, logic pin);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.cmd            <= c;
      req_bus.channel        <= ch;
      req_bus.captured_value <= cap;
      req_bus.counter_now    <= now;
      req_bus.wrap_pending   <= pend;
      req_bus.pin_level      <= pin;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
   endtask

   // random payload; counter value sometimes equal to the captured one
   task automatic send_plain(cts_pkg::cmd_type c, logic [cts_pkg::CH_W-1:0] ch);
      logic [cts_pkg::VALUE_W-1:0] cap;
      logic [cts_pkg::VALUE_W-1:0] now;
      cap = cts_pkg::VALUE_W'($urandom_range(65535));
      now = ($urandom_range(7) == 0) ? cap : cts_pkg::VALUE_W'($urandom_range(65535));
      send_word(c, ch, cap, now, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic send_random_word();
      int                       pick;
      logic [cts_pkg::CH_W-1:0] ch;
      pick = $urandom_range(99);
      ch   = cts_pkg::CH_W'($urandom_range(15));
      if (pick < 45) send_plain(cts_pkg::CMD_CAPTURE, ch);
      else if (pick < 80) send_plain(cts_pkg::CMD_POP, ch);
      else if (pick < 95) send_plain(cts_pkg::CMD_WRAP, ch);
      else send_plain(cts_pkg::CMD_NOP, ch);
   endtask

   task automatic csr_write(cts_pkg::reg_index_type idx,
                            logic [cts_pkg::APB_DW-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_words != 0);
      @(posedge clock);
   endtask

   initial begin
      int                         target;
      logic [cts_pkg::CH_W-1:0]   ch;
      logic [cts_pkg::THR_W-1:0]  thr;
      logic [cts_pkg::MASK_W-1:0] mask;
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.cmd            <= cts_pkg::CMD_NOP;
      req_bus.channel        <= '0;
      req_bus.captured_value <= '0;
      req_bus.counter_now    <= '0;
      req_bus.wrap_pending   <= 1'b0;
      req_bus.pin_level      <= 1'b0;
      psel                   <= 1'b0;
      penable                <= 1'b0;
      pwrite                 <= 1'b0;
      paddr                  <= '0;
      pwdata                 <= '0;
      idle_pct  = 0;
      stall_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed words under reset register values (channel 14 disabled)
      send_word(cts_pkg::CMD_CAPTURE, 4'd0, 16'hFFFF, 16'h0000, 1'b1, 1'b1);
      send_word(cts_pkg::CMD_CAPTURE, 4'd0, 16'h0000, 16'hFFFF, 1'b1, 1'b0);
      send_word(cts_pkg::CMD_CAPTURE, 4'd0, 16'h1234, 16'h1234, 1'b1, 1'b1);
      send_word(cts_pkg::CMD_CAPTURE, 4'd0, 16'h0001, 16'h8000, 1'b0, 1'b0);
      send_word(cts_pkg::CMD_CAPTURE, 4'd14, 16'h5555, 16'hAAAA, 1'b1, 1'b1);
      send_word(cts_pkg::CMD_WRAP, 4'd15, 16'hAAAA, 16'h5555, 1'b1, 1'b1);
      send_word(cts_pkg::CMD_CAPTURE, 4'd15, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
      send_word(cts_pkg::CMD_CAPTURE, 4'd13, 16'h00FF, 16'hFF00, 1'b1, 1'b0);
      repeat (5) send_word(cts_pkg::CMD_POP, 4'd0, 16'h0000, 16'h0000, 1'b0, 1'b0);
      send_word(cts_pkg::CMD_POP, 4'd14, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
      send_word(cts_pkg::CMD_NOP, 4'd3, 16'hFFFF, 16'h0000, 1'b1, 1'b1);
      send_word(cts_pkg::CMD_POP, 4'd15, 16'h0000, 16'h0000, 1'b0, 1'b0);
      send_word(cts_pkg::CMD_WRAP, 4'd0, 16'h0000, 16'h0000, 1'b0, 1'b0);
      send_word(cts_pkg::CMD_CAPTURE, 4'd7, 16'h0000, 16'h0001, 1'b1, 1'b1);
      send_word(cts_pkg::CMD_POP, 4'd7, 16'h0000, 16'h0000, 1'b0, 1'b0);
      send_word(cts_pkg::CMD_POP, 4'd13, 16'h0000, 16'h0000, 1'b0, 1'b0);

      // 64-bit overflow of the timestamp needs 2^47 wraps and is out of reach
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_drained();
         case (seg / 2)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 51; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 51; end
            default: begin idle_pct = 37; stall_pct = 37; end
         endcase
         thr  = THR_SET[seg];
         mask = MASK_SET[seg];
         if (seg == 3 || seg == 6) begin
            thr  = cts_pkg::THR_W'($urandom_range(255));
            mask = cts_pkg::MASK_W'($urandom_range(65535));
         end
         csr_write(cts_pkg::REG_THRESHOLD, cts_pkg::APB_DW'(thr));
         csr_write(cts_pkg::REG_ENABLE, cts_pkg::APB_DW'(mask));
         target = words_sent + SEG_WORDS;
         while (words_sent < target) begin
            ch = cts_pkg::CH_W'($urandom_range(15));
            case ($urandom_range(9))
               0, 1: repeat ($urandom_range(30, 40)) send_plain(cts_pkg::CMD_CAPTURE, ch);
               2, 3, 4: repeat ($urandom_range(4, 36)) send_plain(cts_pkg::CMD_POP, ch);
               default: send_random_word();
            endcase
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
